### rtl/htt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htt_pkg - shared types and constants of the thermostat with timer
// Field widths, register indexes, request codes and conversion constants.
// ---------------------------------------------------------------------------
package htt_pkg;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int ADC_W    = 10;
   localparam int SECS_W   = 17;
   localparam int TEMP_W   = 11;
   localparam int TARGET_W = 10;
   localparam int TRIP_W   = 11;
   localparam int BAND_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Limits
   localparam int TIMER_MAX_SECONDS  = 86400;
   localparam int VALID_LIMIT_TENTHS = 1500;

   // Sample conversion: tenths = floor(adc * 3300 / 1023)
   localparam int ADC_SCALE    = 3300;
   localparam int ADC_DIVISOR  = 1023;
   localparam int SCALED_W     = 22;
   localparam int SCALED_LIMIT = VALID_LIMIT_TENTHS * ADC_DIVISOR;

   // Register reset values
   localparam int TARGET_RESET = 500;
   localparam int TRIP_RESET   = 750;
   localparam int BAND_RESET   = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 2'd0,
      CSR_TRIP   = 2'd1,
      CSR_BAND   = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_POWER  = 2'd2,
      REQ_TIMER  = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [ADC_W-1:0]  adc_sample;
      logic              power_request;
      logic [SECS_W-1:0] timer_seconds;
   } item_type;

   typedef struct packed {
      logic              heater_drive;
      logic              system_active;
      logic              timer_active;
      logic [SECS_W-1:0] seconds_left;
      logic [TEMP_W-1:0] temperature_tenths;
      logic              accepted;
      logic              over_temp;
   } result_type;

   typedef struct packed {
      logic              write_enable;
      csr_index_type     index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

endpackage

### rtl/htt_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htt_in_stage - input register of the thermostat
// Holds one request until the processing stage takes it.
// ---------------------------------------------------------------------------
module htt_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  htt_pkg::item_type in_item,
   input  logic              take,
   output logic              held_valid,
   output htt_pkg::item_type held_item
);

   logic              valid_ff;
   logic              valid_in;
   htt_pkg::item_type item_ff;
   logic              load;

   // A new transfer is taken whenever the stage is empty or is being emptied.
   assign in_stall = valid_ff && !take;
   assign load     = in_valid && !in_stall;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

### rtl/htt_adc_conv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htt_adc_conv - converter reading to tenths of a degree
// Scales by 3300, divides by 1023 through a reciprocal with one correction.
// ---------------------------------------------------------------------------
module htt_adc_conv (
   input  logic [htt_pkg::ADC_W-1:0]  adc_sample,
   output logic [htt_pkg::TEMP_W-1:0] tenths,
   output logic                       in_range
);

   localparam int SUM_W = htt_pkg::SCALED_W + 1;
   localparam int Q_W   = htt_pkg::SCALED_W - 9;

   logic [htt_pkg::SCALED_W-1:0] scaled;
   logic [SUM_W-1:0]             approx_sum;
   logic [Q_W-1:0]               q_est;
   logic [SUM_W-1:0]             remainder;
   logic [Q_W-1:0]               q_fix;

   assign scaled = htt_pkg::SCALED_W'(adc_sample) *
                   htt_pkg::SCALED_W'(htt_pkg::ADC_SCALE);

   // 1/1023 is close to (1 + 1/1024)/1024; the estimate is low by at most one.
   assign approx_sum = SUM_W'(scaled) + SUM_W'(scaled >> 10);
   assign q_est      = Q_W'(approx_sum >> 10);
   assign remainder  = SUM_W'(scaled) - (SUM_W'(q_est) << 10) + SUM_W'(q_est);
   assign q_fix      = (remainder >= SUM_W'(htt_pkg::ADC_DIVISOR)) ? q_est + Q_W'(1) : q_est;

   assign tenths   = q_fix[htt_pkg::TEMP_W-1:0];
   assign in_range = scaled <= htt_pkg::SCALED_W'(htt_pkg::SCALED_LIMIT);

endmodule

### rtl/htt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htt_ctrl - thermostat state, configuration and next-state logic
// Applies one request to the heater, system and timer state.
// ---------------------------------------------------------------------------
module htt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  htt_pkg::csr_write_type        csr,
   input  htt_pkg::item_type             item,
   input  logic                          item_go,
   input  logic [htt_pkg::TEMP_W-1:0]    conv_tenths,
   input  logic                          conv_in_range,
   output htt_pkg::result_type           result
);

   localparam int CMP_W = htt_pkg::TEMP_W + 1;

   logic [htt_pkg::TARGET_W-1:0] target_ff;
   logic [htt_pkg::TRIP_W-1:0]   trip_ff;
   logic [htt_pkg::BAND_W-1:0]   band_ff;

   logic [htt_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic                       heater_ff, heater_in;
   logic                       system_ff, system_in;
   logic                       timer_ff, timer_in;
   logic [htt_pkg::SECS_W-1:0] count_ff, count_in;
   logic [htt_pkg::SECS_W-1:0] count_dec;
   logic                       acc;
   logic                       trip;
   logic                       below_band;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= htt_pkg::TARGET_W'(htt_pkg::TARGET_RESET);
         trip_ff   <= htt_pkg::TRIP_W'(htt_pkg::TRIP_RESET);
         band_ff   <= htt_pkg::BAND_W'(htt_pkg::BAND_RESET);
      end else if (csr.write_enable) begin
         unique case (csr.index)
            htt_pkg::CSR_TARGET: target_ff <= csr.data[htt_pkg::TARGET_W-1:0];
            htt_pkg::CSR_TRIP:   trip_ff   <= csr.data[htt_pkg::TRIP_W-1:0];
            htt_pkg::CSR_BAND:   band_ff   <= csr.data[htt_pkg::BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // temp < target - band, rewritten so no signed threshold is needed.
   assign below_band = (CMP_W'(temp_ff) + CMP_W'(band_ff)) < CMP_W'(target_ff);
   assign count_dec  = (count_ff != '0) ? count_ff - htt_pkg::SECS_W'(1) : count_ff;

   always_comb begin
      temp_in   = temp_ff;
      heater_in = heater_ff;
      system_in = system_ff;
      timer_in  = timer_ff;
      count_in  = count_ff;
      acc       = 1'b1;
      trip      = 1'b0;
      case (item.kind)
         htt_pkg::REQ_SAMPLE: begin
            if (conv_in_range) begin
               temp_in = conv_tenths;
            end
         end
         htt_pkg::REQ_TICK: begin
            if (!system_ff) begin
               heater_in = 1'b0;
            end else if (temp_ff >= trip_ff) begin
               heater_in = 1'b0;
               system_in = 1'b0;
               trip      = 1'b1;
            end else if (below_band) begin
               heater_in = 1'b1;
            end else if (temp_ff > htt_pkg::TEMP_W'(target_ff)) begin
               heater_in = 1'b0;
            end
            if (timer_ff) begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  system_in = 1'b0;
                  timer_in  = 1'b0;
                  heater_in = 1'b0;
               end
            end
         end
         htt_pkg::REQ_POWER: begin
            system_in = item.power_request;
            if (!item.power_request) begin
               timer_in  = 1'b0;
               heater_in = 1'b0;
               count_in  = '0;
            end
         end
         default: begin
            if (item.timer_seconds != '0 &&
                item.timer_seconds <= htt_pkg::SECS_W'(htt_pkg::TIMER_MAX_SECONDS)) begin
               count_in  = item.timer_seconds;
               timer_in  = 1'b1;
               system_in = 1'b1;
            end else begin
               acc = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff   <= '0;
         heater_ff <= 1'b0;
         system_ff <= 1'b0;
         timer_ff  <= 1'b0;
         count_ff  <= '0;
      end else if (item_go) begin
         temp_ff   <= temp_in;
         heater_ff <= heater_in;
         system_ff <= system_in;
         timer_ff  <= timer_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      result.heater_drive       = heater_in;
      result.system_active      = system_in;
      result.timer_active       = timer_in;
      result.seconds_left       = timer_in ? count_in : '0;
      result.temperature_tenths = temp_in;
      result.accepted           = acc;
      result.over_temp          = trip;
   end

   // The heater is never left on once the system is off.
   assert property (@(posedge clock) disable iff (reset) heater_ff |-> system_ff)
      else $error("heater on while system is off");

endmodule

### rtl/hysteresis_thermostat_with_timer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hysteresis_thermostat_with_timer_unit - heater thermostat with timer
// Hysteresis control, over-temperature trip and a countdown timer.
// ---------------------------------------------------------------------------
// Each request (converter sample, one-second tick, power command or timer
// set) produces exactly one result, showing the thermostat state after that
// request. The block takes one transfer per clock cycle: a request is caught
// in the input register, and the conversion and state logic then work it
// out in a single pass and load the result register, so the sustained rate
// is one request every cycle while the consumer does not stall.
// The input side stalls only when the result register is full and the
// consumer is stalling it. Configuration registers (target, trip and band,
// all in tenths of a degree) should be written only while no request is in
// flight; a write to the unused index is ignored.
// ---------------------------------------------------------------------------
module hysteresis_thermostat_with_timer_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [htt_pkg::KIND_W-1:0]        req_type,
   input  logic [htt_pkg::ADC_W-1:0]         req_adc_sample,
   input  logic                              req_power_request,
   input  logic [htt_pkg::SECS_W-1:0]        req_timer_seconds,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_heater_drive,
   output logic                              rsp_system_active,
   output logic                              rsp_timer_active,
   output logic [htt_pkg::SECS_W-1:0]        rsp_seconds_left,
   output logic [htt_pkg::TEMP_W-1:0]        rsp_temperature_tenths,
   output logic                              rsp_accepted,
   output logic                              rsp_over_temp,

   input  logic                              csr_write_enable,
   input  logic [htt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [htt_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   htt_pkg::item_type      req_item;
   htt_pkg::item_type      held_item;
   logic                   held_valid;
   logic                   take;
   htt_pkg::csr_write_type csr;
   logic [htt_pkg::TEMP_W-1:0] conv_tenths;
   logic                   conv_in_range;
   htt_pkg::result_type    result_in;
   htt_pkg::result_type    rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   assign req_item.kind          = htt_pkg::req_kind_type'(req_type);
   assign req_item.adc_sample    = req_adc_sample;
   assign req_item.power_request = req_power_request;
   assign req_item.timer_seconds = req_timer_seconds;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = htt_pkg::csr_index_type'(csr_index);
   assign csr.data         = csr_write_data;

   // The held request is processed whenever the result register is free or
   // its contents are being transferred out in this cycle.
   assign take = held_valid && (!rsp_valid_ff || !rsp_stall);

   htt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_item    (req_item),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   htt_adc_conv u_adc_conv (
      .adc_sample (held_item.adc_sample),
      .tenths     (conv_tenths),
      .in_range   (conv_in_range)
   );

   htt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .item          (held_item),
      .item_go       (take),
      .conv_tenths   (conv_tenths),
      .conv_in_range (conv_in_range),
      .result        (result_in)
   );

   // Result register: filled by a processed request, emptied by a transfer.
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_heater_drive       = rsp_ff.heater_drive;
   assign rsp_system_active      = rsp_ff.system_active;
   assign rsp_timer_active       = rsp_ff.timer_active;
   assign rsp_seconds_left       = rsp_ff.seconds_left;
   assign rsp_temperature_tenths = rsp_ff.temperature_tenths;
   assign rsp_accepted           = rsp_ff.accepted;
   assign rsp_over_temp          = rsp_ff.over_temp;

   // A trip always leaves the heater and the system switched off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.over_temp |-> !rsp_ff.heater_drive && !rsp_ff.system_active)
      else $error("trip result with heater or system still on");

   // Remaining time is reported only while the timer runs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.timer_active |-> rsp_ff.seconds_left == '0)
      else $error("seconds left reported with timer stopped");

   // A request is only processed when it can land in the result register.
   assert property (@(posedge clock) disable iff (reset)
      take |-> !rsp_valid_ff || !rsp_stall)
      else $error("request processed over a stalled result");

endmodule
